### design/r2fft_pkg.sv
// shared constants, types and twiddle table for the radix-2 fft unit
package r2fft_pkg;

    localparam int FRAME_LEN = 1024;
    localparam int LOG_N = $clog2(FRAME_LEN);
    localparam int HALF_N = FRAME_LEN / 2;
    localparam int STAGE_W = $clog2(LOG_N);
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1073741824;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_MUL,
        ST_RND,
        ST_WRA,
        ST_WRB
    } t_state;

    typedef enum logic {
        ACT_PUSH  = 1'b0,
        ACT_FETCH = 1'b1
    } t_action;

    typedef logic signed [16:0] t_tw_tab [HALF_N];

    // taylor series in q2.30, odd selects sine
    function automatic logic signed [63:0] series_q30(logic [63:0] x, bit odd);
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] p;
        logic signed [63:0] sum;
        x2 = (x * x) >> 30;
        t = odd ? x : ONE_Q30;
        sum = 64'sd0;
        for (int i = 0; i < 12; i++) begin
            if ((i % 2) == 1) begin
                sum = sum - $signed(t);
            end else begin
                sum = sum + $signed(t);
            end
            p = (t * x2) >> 30;
            case (i)
                0:  t = odd ? p / 6   : p / 2;
                1:  t = odd ? p / 20  : p / 12;
                2:  t = odd ? p / 42  : p / 30;
                3:  t = odd ? p / 72  : p / 56;
                4:  t = odd ? p / 110 : p / 90;
                5:  t = odd ? p / 156 : p / 132;
                6:  t = odd ? p / 210 : p / 182;
                7:  t = odd ? p / 272 : p / 240;
                8:  t = odd ? p / 342 : p / 306;
                9:  t = odd ? p / 420 : p / 380;
                10: t = odd ? p / 506 : p / 462;
                default: t = odd ? p / 600 : p / 552;
            endcase
        end
        return sum;
    endfunction

    function automatic logic signed [16:0] to_q15(logic signed [63:0] v);
        logic [63:0] c;
        if (v < 0) begin
            c = 64'd0;
        end else if (v > $signed(ONE_Q30)) begin
            c = ONE_Q30;
        end else begin
            c = v;
        end
        return 17'((c + 64'd16384) >> 15);
    endfunction

    function automatic logic signed [16:0] tw_val(int k, bit want_sin);
        bit mirror;
        logic [63:0] kk;
        logic [63:0] a;
        logic signed [16:0] c;
        mirror = (k * 4) > FRAME_LEN;
        kk = mirror ? 64'(HALF_N - k) : 64'(k);
        a = (64'd2 * PI_Q30 * kk) / FRAME_LEN;
        if (want_sin) begin
            return -to_q15(series_q30(a, 1'b1));
        end
        c = to_q15(series_q30(a, 1'b0));
        return mirror ? -c : c;
    endfunction

    function automatic t_tw_tab build_tw(bit want_sin);
        t_tw_tab tab;
        for (int k = 0; k < HALF_N; k++) begin
            tab[k] = tw_val(k, want_sin);
        end
        return tab;
    endfunction

    localparam t_tw_tab TW_RE = build_tw(1'b0);
    localparam t_tw_tab TW_IM = build_tw(1'b1);

    function automatic logic [LOG_N-1:0] bit_rev(logic [LOG_N-1:0] v);
        logic [LOG_N-1:0] r;
        for (int i = 0; i < LOG_N; i++) begin
            r[i] = v[LOG_N-1-i];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] sat32(logic signed [49:0] v);
        if (v > 50'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -50'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    // round half up by 2^-15, then saturate
    function automatic logic signed [31:0] round_sat(logic signed [49:0] v);
        logic signed [49:0] r;
        r = (v + 50'sd16384) >>> 15;
        return sat32(r);
    endfunction

endpackage

### design/radix2_real_fft_unit.sv
// radix-2 dit fft over a frame of real samples with one shared real multiplier
//
//  channel | signals                                        | direction
//  in      | i_in_valid o_in_stall i_in_action i_in_sample  | request in
//  out     | o_out_valid i_out_stall o_out_bin_index
//          | o_out_real_part o_out_imag_part o_out_last_bin | result out
//
// a push writes one sample; after the frame's last push the unit runs (N/2)*log2(N) butterflies,
// one at a time, each using the single real multiplier four times and the single memory write port twice.
// a fetch reads the memory through a registered read port and waits for a free output register.
// reset is synchronous active low and clears control state; the frame memory is not cleared.
// o_in_stall is high while the transform runs, a fetch is under way or a result waits in the output register.
module radix2_real_fft_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_in_action,
    input  logic signed [15:0] i_in_sample,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [9:0]  o_out_bin_index,
    output logic signed [31:0] o_out_real_part,
    output logic signed [31:0] o_out_imag_part,
    output logic        o_out_last_bin
);
    import r2fft_pkg::*;

    logic [63:0] mem [FRAME_LEN];

    t_state r_state, n_state;
    logic [LOG_N-1:0] r_count, n_count;
    logic [LOG_N-1:0] r_rp, n_rp;
    logic r_pending, n_pending;
    logic [STAGE_W-1:0] r_stage, n_stage;
    logic [LOG_N-2:0] r_bfly, n_bfly;
    logic [2:0] r_ph, n_ph;
    logic r_out_valid, n_out_valid;
    logic [LOG_N-1:0] r_fetch_idx;

    logic [63:0] r_rd_a, r_rd_b;
    logic signed [16:0] r_tw_re, r_tw_im;
    logic signed [48:0] r_prod;
    logic signed [49:0] r_acc_re, r_acc_im;
    logic signed [31:0] r_or, r_oi;
    logic [9:0] r_o_bin;
    logic signed [31:0] r_o_re, r_o_im;
    logic r_o_last;

    logic accept;
    logic rd_en;
    logic [LOG_N-1:0] rd_addr_a;
    logic wr_en;
    logic [LOG_N-1:0] wr_addr;
    logic [63:0] wr_data;
    logic [LOG_N-1:0] jx, mask, ia, ib;
    logic [LOG_N-2:0] tw_k;
    logic [STAGE_W-1:0] tw_sh;
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [31:0] er, ei, br, bi;
    logic signed [32:0] sum_re, sum_im, dif_re, dif_im;

    assign er = r_rd_a[63:32];
    assign ei = r_rd_a[31:0];
    assign br = r_rd_b[63:32];
    assign bi = r_rd_b[31:0];

    // butterfly addressing for the current stage
    assign jx = {1'b0, r_bfly};
    assign mask = (LOG_N'(1) << r_stage) - LOG_N'(1);
    assign ia = ((jx & ~mask) << 1) | (jx & mask);
    assign ib = ia | (LOG_N'(1) << r_stage);
    assign tw_sh = STAGE_W'(LOG_N - 1) - r_stage;
    assign tw_k = (LOG_N-1)'((jx & mask) << tw_sh);

    assign sum_re = 33'(er) + 33'(r_or);
    assign sum_im = 33'(ei) + 33'(r_oi);
    assign dif_re = 33'(er) - 33'(r_or);
    assign dif_im = 33'(ei) - 33'(r_oi);

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE) || r_out_valid;

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_rp = r_rp;
        n_pending = r_pending;
        n_stage = r_stage;
        n_bfly = r_bfly;
        n_ph = r_ph;
        n_out_valid = r_out_valid && i_out_stall;
        rd_en = 1'b0;
        rd_addr_a = ia;
        wr_en = 1'b0;
        wr_addr = ia;
        wr_data = {sat32(50'(sum_re)), sat32(50'(sum_im))};
        mul_a = br;
        mul_b = r_tw_re;
        unique case (r_state)
            ST_IDLE: begin
                rd_addr_a = r_rp;
                if (accept) begin
                    if (t_action'(i_in_action) == ACT_PUSH) begin
                        wr_en = 1'b1;
                        wr_addr = bit_rev(r_count);
                        wr_data = {{16{i_in_sample[15]}}, i_in_sample, 32'd0};
                        n_pending = 1'b0;
                        n_rp = '0;
                        n_count = r_count + LOG_N'(1);
                        if (r_count == LOG_N'(FRAME_LEN - 1)) begin
                            n_stage = '0;
                            n_bfly = '0;
                            n_state = ST_LOAD;
                        end
                    end else if (r_pending) begin
                        rd_en = 1'b1;
                        n_state = ST_FETCH;
                        if (r_rp == LOG_N'(HALF_N)) begin
                            n_pending = 1'b0;
                            n_rp = '0;
                        end else begin
                            n_rp = r_rp + LOG_N'(1);
                        end
                    end
                end
            end
            ST_FETCH: begin
                n_out_valid = 1'b1;
                n_state = ST_IDLE;
            end
            ST_LOAD: begin
                rd_en = 1'b1;
                n_ph = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                case (r_ph)
                    3'd0: begin mul_a = br; mul_b = r_tw_re; end
                    3'd1: begin mul_a = bi; mul_b = r_tw_im; end
                    3'd2: begin mul_a = br; mul_b = r_tw_im; end
                    default: begin mul_a = bi; mul_b = r_tw_re; end
                endcase
                n_ph = r_ph + 3'd1;
                if (r_ph == 3'd4) begin
                    n_state = ST_RND;
                end
            end
            ST_RND: begin
                n_state = ST_WRA;
            end
            ST_WRA: begin
                wr_en = 1'b1;
                n_state = ST_WRB;
            end
            ST_WRB: begin
                wr_en = 1'b1;
                wr_addr = ib;
                wr_data = {sat32(50'(dif_re)), sat32(50'(dif_im))};
                n_state = ST_LOAD;
                n_bfly = r_bfly + (LOG_N-1)'(1);
                if (r_bfly == (LOG_N-1)'(HALF_N - 1)) begin
                    n_stage = r_stage + STAGE_W'(1);
                    if (r_stage == STAGE_W'(LOG_N - 1)) begin
                        n_pending = 1'b1;
                        n_rp = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_rp <= '0;
            r_pending <= 1'b0;
            r_stage <= '0;
            r_bfly <= '0;
            r_ph <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_rp <= n_rp;
            r_pending <= n_pending;
            r_stage <= n_stage;
            r_bfly <= n_bfly;
            r_ph <= n_ph;
            r_out_valid <= n_out_valid;
        end
    end

    // frame memory: one write port, two registered read ports
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_a <= mem[rd_addr_a];
            r_rd_b <= mem[ib];
            r_tw_re <= TW_RE[tw_k];
            r_tw_im <= TW_IM[tw_k];
        end
    end

    // shared multiplier and accumulator, rounding, and fetch output registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && accept) begin
            r_fetch_idx <= r_rp;
        end
        if (r_state == ST_MUL) begin
            r_prod <= mul_a * mul_b;
            case (r_ph)
                3'd1: r_acc_re <= 50'(r_prod);
                3'd2: r_acc_re <= r_acc_re - 50'(r_prod);
                3'd3: r_acc_im <= 50'(r_prod);
                3'd4: r_acc_im <= r_acc_im + 50'(r_prod);
                default: ;
            endcase
        end
        if (r_state == ST_RND) begin
            r_or <= round_sat(r_acc_re);
            r_oi <= round_sat(r_acc_im);
        end
        if (r_state == ST_FETCH) begin
            r_o_bin <= 10'(r_fetch_idx);
            r_o_re <= r_rd_a[63:32];
            r_o_im <= r_rd_a[31:0];
            r_o_last <= (r_fetch_idx == LOG_N'(HALF_N));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_bin_index = r_o_bin;
    assign o_out_real_part = r_o_re;
    assign o_out_imag_part = r_o_im;
    assign o_out_last_bin = r_o_last;

endmodule
